[hdl/tst_pkg.sv]
package tst_pkg;

  // field widths
  localparam int TIME_W  = 42;
  localparam int SLOT_W  = 12;
  localparam int CLASS_W = 2;
  localparam int FRAME_W = 40;

  // largest forward distance that is caught up in one item
  localparam int MAX_ADVANCE = 2;
  localparam int STEP_W      = $clog2(MAX_ADVANCE + 1);

  localparam logic [SLOT_W-1:0] FRAME_SLOTS = 12'd2250;
  localparam logic [SLOT_W-1:0] LAST_SLOT   = 12'd2249;

  // time reduction: 60000 ms is exactly one frame of 2250 slots
  localparam int MOD_BITS  = 3;
  localparam int MOD_STEPS = TIME_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);
  localparam int REM_W     = 16;
  localparam logic [REM_W:0] MOD_BASE = 17'd60000;

  // divide by 5 through a reciprocal, exact for operands below 2^18
  localparam int QUO_W       = 14;
  localparam int RECIP_W     = 16;
  localparam int PROD_W      = QUO_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP5 = 16'd52429;

  // channel classes
  localparam logic [CLASS_W-1:0] CH_BBSC = 2'd0;
  localparam logic [CLASS_W-1:0] CH_ASC  = 2'd1;
  localparam logic [CLASS_W-1:0] CH_RAC  = 2'd2;
  localparam logic [CLASS_W-1:0] CH_DC   = 2'd3;

  // report frame preamble bytes
  localparam logic [7:0] FRM_B0 = 8'h55;
  localparam logic [7:0] FRM_B1 = 8'hAA;
  localparam logic [7:0] FRM_B2 = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_MUL,
    ST_EXP,
    ST_DEC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mod_step;
    logic mul;
    logic exp_calc;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last_step;
    logic out_free;
  } stat_t;

  function automatic logic [CLASS_W-1:0] channel_of(input logic [SLOT_W-1:0] s);
    logic [CLASS_W-1:0] c;
    if (s <= 12'd89) c = CH_BBSC;
    else if ((s >= 12'd90 && s <= 12'd179) || (s >= 12'd810 && s <= 12'd899) ||
             (s >= 12'd1530 && s <= 12'd1619)) c = CH_ASC;
    else if (s >= 12'd2070 && s <= LAST_SLOT) c = CH_RAC;
    else c = CH_DC;
    return c;
  endfunction

  // one bit of a restoring modulo step
  function automatic logic [REM_W-1:0] mod_bit(input logic [REM_W-1:0] r, input logic b);
    logic [REM_W:0] v;
    v = {r, b};
    if (v >= MOD_BASE) v = v - MOD_BASE;
    return v[REM_W-1:0];
  endfunction

endpackage

[hdl/tst_ctrl.sv]
module tst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tst_pkg::stat_t stat,
  output tst_pkg::cmd_t  cmd
);
  import tst_pkg::*;

  state_t                state, state_next;
  logic [MOD_CNT_W-1:0]  cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_next    = '0;
          state_next  = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EXP;
      end
      ST_EXP: begin
        cmd.exp_calc = 1'b1;
        state_next   = ST_DEC;
      end
      ST_DEC: begin
        if (stat.skip) begin
          state_next = ST_IDLE;
        end else begin
          cmd.decide = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_step) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hdl/tst_dp.sv]
module tst_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tst_pkg::cmd_t                 cmd,
  output tst_pkg::stat_t                stat,
  input  logic                          cfg_valid,
  input  logic                          cfg_data,
  input  logic                          opcode,
  input  logic [tst_pkg::TIME_W-1:0]    time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tst_pkg::SLOT_W-1:0]    slot_number,
  output logic [tst_pkg::CLASS_W-1:0]   channel_class,
  output logic                          report_valid,
  output logic [tst_pkg::FRAME_W-1:0]   report_frame,
  output logic                          last
);
  import tst_pkg::*;

  logic                  report_enable;
  logic                  op_track;
  logic [TIME_W-1:0]     t_sh;
  logic [REM_W-1:0]      rem;
  logic [PROD_W-1:0]     prod;
  logic [SLOT_W-1:0]     expected;
  logic [SLOT_W-1:0]     current_slot;
  logic [STEP_W-1:0]     steps_left;

  logic [REM_W-1:0]      rem_next;
  logic [REM_W+1:0]      rem_x3;
  logic [QUO_W-1:0]      quo16;
  logic [SLOT_W:0]       fwd_wide;
  logic [SLOT_W-1:0]     fwd;
  logic [STEP_W-1:0]     step_count;
  logic [SLOT_W-1:0]     slot_inc;
  logic [SLOT_W-1:0]     slot_new;

  // MOD_BITS remainder bits per cycle, msb first
  always_comb begin
    rem_next = rem;
    for (int i = 0; i < MOD_BITS; i++) begin
      rem_next = mod_bit(rem_next, t_sh[TIME_W-1-i]);
    end
  end

  assign rem_x3 = {2'b00, rem} + {1'b0, rem, 1'b0};
  assign quo16  = rem_x3[REM_W+1:4];

  always_comb begin
    if (expected >= current_slot) fwd_wide = {1'b0, expected} - {1'b0, current_slot};
    else fwd_wide = {1'b0, expected} + {1'b0, FRAME_SLOTS} - {1'b0, current_slot};
    fwd = fwd_wide[SLOT_W-1:0];
    if (fwd <= SLOT_W'(MAX_ADVANCE)) step_count = fwd[STEP_W-1:0];
    else step_count = STEP_W'(1);
  end

  assign slot_inc = (current_slot == LAST_SLOT) ? '0 : current_slot + 1'b1;
  assign slot_new = op_track ? slot_inc : expected;

  assign stat.skip      = op_track && (expected == current_slot);
  assign stat.last_step = (steps_left == STEP_W'(1));
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_enable <= 1'b0;
      current_slot  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) report_enable <= cfg_data;
      if (cmd.emit) begin
        current_slot <= slot_new;
        out_valid    <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_track <= opcode;
      t_sh     <= time_ms;
      rem      <= '0;
    end
    if (cmd.mod_step) begin
      rem  <= rem_next;
      t_sh <= {t_sh[TIME_W-MOD_BITS-1:0], {MOD_BITS{1'b0}}};
    end
    if (cmd.mul) prod <= {{RECIP_W{1'b0}}, quo16} * {{QUO_W{1'b0}}, RECIP5};
    if (cmd.exp_calc) expected <= prod[PROD_W-1 -: SLOT_W];
    if (cmd.decide) steps_left <= op_track ? step_count : STEP_W'(1);
    if (cmd.emit) begin
      steps_left    <= steps_left - 1'b1;
      slot_number   <= slot_new;
      channel_class <= channel_of(slot_new);
      report_valid  <= report_enable;
      report_frame  <= {FRM_B0, FRM_B1, FRM_B2, {(16 - SLOT_W){1'b0}}, slot_new};
      last          <= (steps_left == STEP_W'(1));
    end
  end

endmodule

[hdl/tdma_slot_tracker_unit.sv]
// an input beat passes load, time reduction (3 time bits per cycle), multiply, slot
// calculation and decision before its first result enters the output register; an item
// gives 0 to 2 results, and a new beat is taken only in idle after its last result
// reset (rst, synchronous, active high) clears the stored slot, report_enable
// and the output valid, and returns the controller to idle
module tdma_slot_tracker_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: report_enable in bit 0
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [tst_pkg::TIME_W-1:0]    time_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tst_pkg::SLOT_W-1:0]    slot_number,
  output logic [tst_pkg::CLASS_W-1:0]   channel_class,
  output logic                          report_valid,
  output logic [tst_pkg::FRAME_W-1:0]   report_frame,
  output logic                          last
);
  import tst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // the register write is registered and applies to results emitted after it, never held off
  assign cfg_ready = 1'b1;

  // controller: sequences the time reduction, the divide, the slot decision
  // and the result beats; waits on a full output register
  tst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: time mod one frame, slot = 3*r/80, forward distance, stored
  // slot, and an output register that frees the controller for the next beat
  tst_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .time_ms       (time_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot_number   (slot_number),
    .channel_class (channel_class),
    .report_valid  (report_valid),
    .report_frame  (report_frame),
    .last          (last)
  );

endmodule
